[rtl/segment_pair_min_distance_top_assert.svh]
// Assertion macros for the segment pair distance block.
// Used by the top level; the checks go away when ASSERT_OFF is set.
`ifndef SEGMENT_PAIR_MIN_DISTANCE_TOP_ASSERT_SVH
`define SEGMENT_PAIR_MIN_DISTANCE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every clk edge outside reset.
`define SPMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every clk edge outside reset.
`define SPMD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPMD_ASSERT_IMP(lbl, ante, cons, msg)
`define SPMD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/spmd_pkg.sv]
// Shared constants for the segment pair distance pipeline.
// No dependencies.
package spmd_pkg;
    // Fraction bits of the projection parameter t; t = 1.0 is 2**T_FRAC.
    localparam int T_FRAC = 30;
endpackage

[rtl/spmd_seg_if.sv]
// Input channel: one pair of segments per transfer.
// Valid/ready handshake; no package dependency.
interface spmd_seg_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

[rtl/spmd_dist_if.sv]
// Output channel: one distance per transfer.
// Valid/ready handshake; no package dependency.
interface spmd_dist_if #(parameter int OW = 33);
    logic          valid;
    logic          ready;
    logic [OW-1:0] min_distance;

    modport source (output valid, min_distance, input ready);
    modport sink (input valid, min_distance, output ready);
endinterface

[rtl/spmd_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, T_FRAC stages.
// Depends on spmd_pkg for T_FRAC. Carries a side vector along with the data.
module spmd_divider #(
    parameter int W  = 66,
    parameter int SW = 134
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [spmd_pkg::T_FRAC-1:0] quotient,
    output logic [SW-1:0] side_out
);
    import spmd_pkg::*;

    localparam int QB = T_FRAC;

    logic          vld_reg  [QB];
    logic [W-1:0]  rem_reg  [QB];
    logic [W-1:0]  div_reg  [QB];
    logic [QB-1:0] q_reg    [QB];
    logic [SW-1:0] side_reg [QB];

    for (genvar s = 0; s < QB; s++) begin : g_st
        logic          vld_in;
        logic [W-1:0]  rem_in;
        logic [W-1:0]  div_in;
        logic [QB-1:0] q_in;
        logic [SW-1:0] side_in_s;
        logic [W:0]    shifted;
        logic          ge;
        logic [W-1:0]  rem_next;
        logic [QB-1:0] q_next;

        if (s == 0) begin : g_first
            assign vld_in    = in_valid;
            assign rem_in    = dividend;
            assign div_in    = divisor;
            assign q_in      = '0;
            assign side_in_s = side_in;
        end
        else begin : g_rest
            assign vld_in    = vld_reg[s-1];
            assign rem_in    = rem_reg[s-1];
            assign div_in    = div_reg[s-1];
            assign q_in      = q_reg[s-1];
            assign side_in_s = side_reg[s-1];
        end

        // Shift in a zero, subtract the divisor when it fits
        assign shifted  = {rem_in, 1'b0};
        assign ge       = shifted >= {1'b0, div_in};
        assign rem_next = ge ? W'(shifted - {1'b0, div_in}) : shifted[W-1:0];
        if (QB > 1) begin : g_qs
            assign q_next = {q_in[QB-2:0], ge};
        end
        else begin : g_q1
            assign q_next = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                div_reg[s]  <= div_in;
                q_reg[s]    <= q_next;
                side_reg[s] <= side_in_s;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign quotient  = q_reg[QB-1];
    assign side_out  = side_reg[QB-1];
endmodule

[rtl/spmd_isqrt.sv]
// Pipelined integer square root, one root bit per stage, Q stages.
// Depends on spmd_pkg only by convention; result is floor(sqrt(radicand)).
module spmd_isqrt #(
    parameter int Q = 35
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [2*Q-1:0] radicand,
    output logic           out_valid,
    output logic [Q-1:0]   root
);
    import spmd_pkg::*;

    logic           vld_reg  [Q];
    logic [2*Q-1:0] rad_reg  [Q];
    logic [Q+1:0]   rem_reg  [Q];
    logic [Q-1:0]   root_reg [Q];

    for (genvar s = 0; s < Q; s++) begin : g_st
        logic           vld_in;
        logic [2*Q-1:0] rad_in;
        logic [Q+1:0]   rem_in;
        logic [Q-1:0]   root_in;
        logic [Q+2:0]   rem_sh;
        logic [Q+2:0]   trial;
        logic           ge;
        logic [Q+1:0]   rem_next;
        logic [Q-1:0]   root_next;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign rad_in  = rad_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // Bring down two radicand bits, try root*4+1
        assign rem_sh    = {rem_in[Q:0], rad_in[2*Q-1:2*Q-2]};
        assign trial     = {1'b0, root_in, 2'b01};
        assign ge        = rem_sh >= trial;
        assign rem_next  = ge ? (Q+2)'(rem_sh - trial) : rem_sh[Q+1:0];
        assign root_next = {root_in[Q-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= {rad_in[2*Q-3:0], 2'b00};
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[Q-1];
    assign root      = root_reg[Q-1];
endmodule

[rtl/spmd_point_seg.sv]
// One point-to-segment distance lane: differences, dot products, divider
// for t, projection, residual square sum and square root. Uses spmd_pkg.
module spmd_point_seg #(
    parameter int CW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] px,
    input  logic signed [CW-1:0] py,
    input  logic signed [CW-1:0] sx,
    input  logic signed [CW-1:0] sy,
    input  logic signed [CW-1:0] ex,
    input  logic signed [CW-1:0] ey,
    output logic                 out_valid,
    output logic [CW+2:0]        seg_dist
);
    import spmd_pkg::*;

    localparam int D  = CW + 1;
    localparam int W  = 2 * D;
    localparam int SW = 4 * D + 2;
    localparam int TW = T_FRAC + 1;
    localparam int MW = D + TW + 1;
    localparam int R  = D + 1;
    localparam int Q  = CW + 3;

    // Stage 1: direction and offset vectors
    logic                v1_reg;
    logic signed [D-1:0] dx1_reg, dy1_reg, vx1_reg, vy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= $signed({ex[CW-1], ex}) - $signed({sx[CW-1], sx});
            dy1_reg <= $signed({ey[CW-1], ey}) - $signed({sy[CW-1], sy});
            vx1_reg <= $signed({px[CW-1], px}) - $signed({sx[CW-1], sx});
            vy1_reg <= $signed({py[CW-1], py}) - $signed({sy[CW-1], sy});
        end
    end

    // Stage 2: squared length and dot product terms
    logic                v2_reg;
    logic signed [W-1:0] dxx2_reg, dyy2_reg, vxd2_reg, vyd2_reg;
    logic signed [D-1:0] dx2_reg, dy2_reg, vx2_reg, vy2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxx2_reg <= dx1_reg * dx1_reg;
            dyy2_reg <= dy1_reg * dy1_reg;
            vxd2_reg <= vx1_reg * dx1_reg;
            vyd2_reg <= vy1_reg * dy1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            vx2_reg  <= vx1_reg;
            vy2_reg  <= vy1_reg;
        end
    end

    // Stage 3: sums and the clamp decision for t
    logic signed [W:0]   dot_s;
    logic [W-1:0]        len2_s;
    logic                dot_pos, dot_ge;
    logic                v3_reg;
    logic                t_one3_reg, t_div3_reg;
    logic [W-1:0]        len3_reg, num3_reg;
    logic signed [D-1:0] dx3_reg, dy3_reg, vx3_reg, vy3_reg;

    assign dot_s   = $signed({vxd2_reg[W-1], vxd2_reg})
                   + $signed({vyd2_reg[W-1], vyd2_reg});
    assign len2_s  = dxx2_reg + dyy2_reg;
    assign dot_pos = !dot_s[W] && (dot_s != '0);
    assign dot_ge  = dot_s[W-1:0] >= len2_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_one3_reg <= dot_pos && dot_ge;
            t_div3_reg <= dot_pos && !dot_ge;
            len3_reg   <= len2_s;
            num3_reg   <= (dot_pos && !dot_ge) ? dot_s[W-1:0] : '0;
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            vx3_reg    <= vx2_reg;
            vy3_reg    <= vy2_reg;
        end
    end

    // Divider: t = floor(dot * 2**T_FRAC / len2) when 0 < dot < len2
    logic                v_div;
    logic [T_FRAC-1:0]   q_div;
    logic [SW-1:0]       side_div;
    logic                t_one_d, t_div_d;
    logic signed [D-1:0] dx_d, dy_d, vx_d, vy_d;

    spmd_divider #(
        .W  (W),
        .SW (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .dividend  (num3_reg),
        .divisor   (len3_reg),
        .side_in   ({t_div3_reg, t_one3_reg, dx3_reg, dy3_reg, vx3_reg, vy3_reg}),
        .out_valid (v_div),
        .quotient  (q_div),
        .side_out  (side_div)
    );

    assign {t_div_d, t_one_d, dx_d, dy_d, vx_d, vy_d} = side_div;

    // Stage 4: pick t and scale the direction by it
    logic [TW-1:0]        t_val;
    logic                 v4_reg;
    logic signed [MW-1:0] px4_reg, py4_reg;
    logic signed [D-1:0]  vx4_reg, vy4_reg;

    assign t_val = {t_one_d, (t_div_d ? q_div : T_FRAC'(0))};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v_div;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px4_reg <= dx_d * $signed({1'b0, t_val});
            py4_reg <= dy_d * $signed({1'b0, t_val});
            vx4_reg <= vx_d;
            vy4_reg <= vy_d;
        end
    end

    // Stage 5: residual from the projected point, offset floored
    logic signed [MW-1:0] offx, offy;
    logic                 v5_reg;
    logic signed [R-1:0]  rx5_reg, ry5_reg;

    assign offx = px4_reg >>> T_FRAC;
    assign offy = py4_reg >>> T_FRAC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx5_reg <= $signed({vx4_reg[D-1], vx4_reg}) - $signed({offx[D-1], offx[D-1:0]});
            ry5_reg <= $signed({vy4_reg[D-1], vy4_reg}) - $signed({offy[D-1], offy[D-1:0]});
        end
    end

    // Stage 6: squares of the residual
    logic                  v6_reg;
    logic signed [2*R-1:0] rxx6_reg, ryy6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rxx6_reg <= rx5_reg * rx5_reg;
            ryy6_reg <= ry5_reg * ry5_reg;
        end
    end

    // Stage 7: squared distance, both terms non-negative
    logic           v7_reg;
    logic [2*Q-1:0] sq7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq7_reg <= (2*Q)'({1'b0, rxx6_reg}) + (2*Q)'({1'b0, ryy6_reg});
        end
    end

    // Square root stages
    spmd_isqrt #(
        .Q (Q)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .radicand  (sq7_reg),
        .out_valid (out_valid),
        .root      (seg_dist)
    );
endmodule

[rtl/segment_pair_min_distance_top.sv]
// Top level: smallest distance between two 2-D segments.
// Depends on spmd_pkg, spmd_seg_if, spmd_dist_if, spmd_point_seg and the assert macros.
//
//  port  | dir  | payload                                   | transfer
//  seg   | sink | a_start_x .. b_end_y, COORD_WIDTH signed  | one segment pair
//  res   | src  | min_distance, COORD_WIDTH+1 unsigned      | one distance
//
// One pair enters per cycle while res is not stalled. The 30-stage divider for t
// and the root-bit-per-stage square root set the depth. Reset clears only
// valid bits.
// A stall on res freezes every stage at once; seg.ready drops in the same cycle.
`include "segment_pair_min_distance_top_assert.svh"
module segment_pair_min_distance_top #(
    parameter int COORD_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    spmd_seg_if.sink    seg,
    spmd_dist_if.source res
);
    import spmd_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int Q  = CW + 3;
    localparam int OW = CW + 1;

    logic         en;
    logic [3:0]   lane_vld;
    logic [Q-1:0] lane_dist [4];

    logic         m1_vld_reg;
    logic [Q-1:0] m1a_reg, m1b_reg;
    logic         out_vld_reg;
    logic [OW-1:0] out_dist_reg;
    logic [Q-1:0] m2;
    logic         stall;
    logic         adv_m1;

    // Advance the whole pipeline unless the output is held
    assign en        = !out_vld_reg || res.ready;
    assign seg.ready = en;

    // Endpoints of A against B, then endpoints of B against A
    spmd_point_seg #(.CW (CW)) u_lane0 (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (seg.valid),
        .px (seg.a_start_x), .py (seg.a_start_y),
        .sx (seg.b_start_x), .sy (seg.b_start_y),
        .ex (seg.b_end_x),   .ey (seg.b_end_y),
        .out_valid (lane_vld[0]), .seg_dist (lane_dist[0])
    );
    spmd_point_seg #(.CW (CW)) u_lane1 (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (seg.valid),
        .px (seg.a_end_x),   .py (seg.a_end_y),
        .sx (seg.b_start_x), .sy (seg.b_start_y),
        .ex (seg.b_end_x),   .ey (seg.b_end_y),
        .out_valid (lane_vld[1]), .seg_dist (lane_dist[1])
    );
    spmd_point_seg #(.CW (CW)) u_lane2 (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (seg.valid),
        .px (seg.b_start_x), .py (seg.b_start_y),
        .sx (seg.a_start_x), .sy (seg.a_start_y),
        .ex (seg.a_end_x),   .ey (seg.a_end_y),
        .out_valid (lane_vld[2]), .seg_dist (lane_dist[2])
    );
    spmd_point_seg #(.CW (CW)) u_lane3 (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (seg.valid),
        .px (seg.b_end_x),   .py (seg.b_end_y),
        .sx (seg.a_start_x), .sy (seg.a_start_y),
        .ex (seg.a_end_x),   .ey (seg.a_end_y),
        .out_valid (lane_vld[3]), .seg_dist (lane_dist[3])
    );

    // Minimum tree, first level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg  <= lane_vld[0];
            out_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1a_reg <= (lane_dist[1] < lane_dist[0]) ? lane_dist[1] : lane_dist[0];
            m1b_reg <= (lane_dist[3] < lane_dist[2]) ? lane_dist[3] : lane_dist[2];
        end
    end

    // Second level and saturation into the output register
    assign m2 = (m1b_reg < m1a_reg) ? m1b_reg : m1a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dist_reg <= (m2[Q-1:OW] != '0) ? {OW{1'b1}} : m2[OW-1:0];
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.min_distance = out_dist_reg;

    // Conditions watched by the checks below
    assign stall  = out_vld_reg && !res.ready;
    assign adv_m1 = m1_vld_reg && en;

    `SPMD_ASSERT_IMP(a_lanes_aligned, 1'b1, (&lane_vld) || !(|lane_vld), "lanes out of step")
    `SPMD_ASSERT_NXT(a_stall_freezes, stall, $stable(lane_vld) && $stable(m1a_reg), "moved in stall")
    `SPMD_ASSERT_NXT(a_min_order, adv_m1, out_dist_reg <= $past(m2), "minimum above a candidate")
endmodule

[verif/tb_segment_pair_min_distance_top.sv]
// Self-checking testbench for segment_pair_min_distance_top.
// Depends on spmd_pkg, spmd_seg_if, spmd_dist_if and the block itself; predicts
// each distance not typed in with exact wide integer math; checks results in order.
module tb_segment_pair_min_distance_top;
    import spmd_pkg::*;

    localparam int CW       = 32;
    localparam int OW       = CW + 1;
    localparam int LATENCY  = 7 + T_FRAC + (CW + 3) + 2;
    localparam int WATCHDOG = 4000;
    localparam int N_RANDOM = 1280;
    localparam int HOLD_LEN = 400;
    localparam logic [OW-1:0] DIST_MAX = {OW{1'b1}};

    typedef logic signed [127:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t        c[8];   // a_start x/y, a_end x/y, b_start x/y, b_end x/y
        bit            known;  // expected distance typed in below
        logic [OW-1:0] want_dist;
    } pair_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spmd_seg_if  #(.CW(CW)) seg_if ();
    spmd_dist_if #(.OW(OW)) dist_if ();

    segment_pair_min_distance_top #(.COORD_WIDTH(CW)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg_if),
        .res   (dist_if)
    );

    always #2 clk = ~clk;

    logic [OW-1:0] dist_expect_q[$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    bit            idle_off = 1'b0;
    bit            hold_request = 1'b0;
    bit            stim_done = 1'b0;

    // Exact floor(sqrt(v)) for v below 2**126.
    function automatic longint unsigned floor_sqrt(wide_t v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (wide_t'({64'd0, trial}) * wide_t'({64'd0, trial}) <= v)
                root = trial;
        end
        return root;
    endfunction

    // Distance from point p to segment s..e: project, clamp t to [0,1], measure.
    function automatic longint unsigned point_to_segment(wide_t px, wide_t py, wide_t sx,
                                                         wide_t sy, wide_t ex, wide_t ey);
        wide_t dx, dy, vx, vy, seg_len2, proj, t, rx, ry;
        dx = ex - sx;
        dy = ey - sy;
        vx = px - sx;
        vy = py - sy;
        seg_len2 = dx * dx + dy * dy;
        proj = vx * dx + vy * dy;
        t = 0;
        if (seg_len2 != 0 && proj > 0)
        begin
            if (seg_len2 <= proj)
                t = wide_t'(1) <<< T_FRAC;
            else
                t = (proj <<< T_FRAC) / seg_len2;
        end
        // floor the offset toward minus infinity on each axis
        rx = vx - ((dx * t) >>> T_FRAC);
        ry = vy - ((dy * t) >>> T_FRAC);
        return floor_sqrt(rx * rx + ry * ry);
    endfunction

    function automatic logic [OW-1:0] segment_gap(coord_t c[8]);
        wide_t         w[8];
        longint unsigned best, d;
        foreach (c[i]) w[i] = c[i];
        best = point_to_segment(w[0], w[1], w[4], w[5], w[6], w[7]);
        d = point_to_segment(w[2], w[3], w[4], w[5], w[6], w[7]);
        if (d < best) best = d;
        d = point_to_segment(w[4], w[5], w[0], w[1], w[2], w[3]);
        if (d < best) best = d;
        d = point_to_segment(w[6], w[7], w[0], w[1], w[2], w[3]);
        if (d < best) best = d;
        if (best > longint'(DIST_MAX)) best = DIST_MAX;
        return best[OW-1:0];
    endfunction

    localparam coord_t CMIN = 32'sh8000_0000;
    localparam coord_t CMAX = 32'sh7FFF_FFFF;
    localparam coord_t ONE  = 32'sh0001_0000;

    pair_row_t directed_rows[] = '{
        // all zero: both segments collapse onto the origin
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0},
        // two points one unit apart
        '{'{0, 0, 0, 0, ONE, 0, ONE, 0}, 1, 33'h1_0000},
        // zero-length A against a long B: distance to B's line
        '{'{0, ONE, 0, ONE, -ONE, 0, ONE, 0}, 1, 33'h1_0000},
        // shared endpoint
        '{'{0, 0, ONE, ONE, ONE, ONE, 3 * ONE, 0}, 1, 0},
        // crossing segments: not detected, minimum of four
        '{'{-ONE, 0, ONE, 0, 0, -ONE, 0, ONE}, 0, 0},
        // collinear overlapping
        '{'{0, 0, 4 * ONE, 0, ONE, 0, 2 * ONE, 0}, 1, 0},
        // parallel, one unit apart
        '{'{0, 0, 4 * ONE, 0, 0, ONE, 4 * ONE, ONE}, 1, 33'h1_0000},
        // projection beyond the end clamps t to one
        '{'{0, 0, ONE, 0, 3 * ONE, 0, 3 * ONE, 0}, 1, 33'h2_0000},
        // projection before the start clamps t to zero
        '{'{0, 0, ONE, 0, -2 * ONE, 0, -2 * ONE, 0}, 1, 33'h2_0000},
        // opposite corners of the coordinate range
        '{'{CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX}, 0, 0},
        '{'{CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN}, 0, 0},
        // full-range segments
        '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 0, 0},
        '{'{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX}, 0, 0},
        '{'{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN}, 0, 0},
        // fractional oblique projection
        '{'{1, 3, 70001, -12345, 5000, 40000, -3, 9}, 0, 0},
        '{'{-1, -1, -1, -1, 0, 0, 0, 0}, 0, 0}
    };

    // Random segment pair: full range, small, degenerate or touching.
    function automatic pair_row_t random_pair();
        pair_row_t r;
        int        kind;
        kind = $urandom_range(0, 9);
        foreach (r.c[i])
        begin
            if (kind < 3)
                r.c[i] = $urandom;
            else if (kind < 6)
                r.c[i] = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            else
                r.c[i] = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        end
        case (kind)
            6: begin r.c[2] = r.c[0]; r.c[3] = r.c[1]; end
            7: begin r.c[4] = r.c[2]; r.c[5] = r.c[3]; end
            8: begin r.c[6] = r.c[4]; r.c[7] = r.c[5]; r.c[2] = r.c[0]; r.c[3] = r.c[1]; end
            default: ;
        endcase
        r.known = 1'b0;
        r.want_dist = '0;
        return r;
    endfunction

    task automatic send_pair(pair_row_t r);
        seg_if.valid     <= 1'b1;
        seg_if.a_start_x <= r.c[0];
        seg_if.a_start_y <= r.c[1];
        seg_if.a_end_x   <= r.c[2];
        seg_if.a_end_y   <= r.c[3];
        seg_if.b_start_x <= r.c[4];
        seg_if.b_start_y <= r.c[5];
        seg_if.b_end_x   <= r.c[6];
        seg_if.b_end_y   <= r.c[7];
        @(posedge clk);
        while (!seg_if.ready)
            @(posedge clk);
        dist_expect_q = {dist_expect_q, (r.known ? r.want_dist : segment_gap(r.c))};
        // idle the sender between transfers now and then
        if (!idle_off && $urandom_range(0, 99) < 33)
        begin
            seg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // Sender: directed rows, then random pairs in phases.
    initial
    begin
        seg_if.valid     = 1'b0;
        seg_if.a_start_x = '0;
        seg_if.a_start_y = '0;
        seg_if.a_end_x   = '0;
        seg_if.a_end_y   = '0;
        seg_if.b_start_x = '0;
        seg_if.b_start_y = '0;
        seg_if.b_end_x   = '0;
        seg_if.b_end_y   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_pair(directed_rows[i]);
        // drain the pipe before the random part
        seg_if.valid <= 1'b0;
        wait (dist_expect_q.size() == 0);
        @(posedge clk);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            idle_off = (n >= 300 && n < 600);
            if (n == 800)
                hold_request = 1'b1;
            send_pair(random_pair());
        end
        seg_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: check each transfer, then pick the next ready.
    initial
    begin
        int hold_left;
        hold_left = 0;
        dist_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dist_if.valid && dist_if.ready)
            begin
                if (dist_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected distance %0d", dist_if.min_distance);
                end
                else
                begin
                    logic [OW-1:0] want;
                    want = dist_expect_q.pop_front();
                    if (dist_if.min_distance !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("min_distance mismatch: expected %0d got %0d",
                                     want, dist_if.min_distance);
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dist_if.ready <= 1'b0;
            end
            else
                dist_if.ready <= idle_off || ($urandom_range(0, 99) >= 33);
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((seg_if.valid && seg_if.ready) || (dist_if.valid && dist_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("segment_pair_min_distance_top verification failed");
            $finish;
        end
    end

    // Finish once everything has drained and the tail has passed.
    initial
    begin
        wait (stim_done && dist_expect_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && dist_expect_q.size() == 0)
            $display("segment_pair_min_distance_top verification clean");
        else
            $display("segment_pair_min_distance_top verification failed");
        $finish;
    end
endmodule
